// ===== sv/gaussian_blur_rgba_clamped_assert.svh =====
// ----------------------------------------------------------------------------
// Gaussian blur assertion macros
// Concurrent checks on clk, disabled while arst_n is low; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_RGBA_CLAMPED_ASSERT_SVH
`define GAUSSIAN_BLUR_RGBA_CLAMPED_ASSERT_SVH
`ifndef SYNTHESIS
`define GBR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GBR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GBR_ASSERT_IMP(lbl, ante, cons, msg)
`define GBR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/gbr_pkg.sv =====
// ----------------------------------------------------------------------------
// Gaussian blur package
// Field widths, register and opcode codes, weight ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package gbr_pkg;

	localparam int COORD_W   = 6;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 32;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int WGT_W     = 16;
	localparam int WSUM_W    = 21;
	localparam int ACC_W     = 29;
	localparam int PROD_W    = WGT_W + CH_W;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGMA  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd3;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_BLUR  = 1'b1;

	localparam logic [6:0] RST_ROWS   = 7'd64;
	localparam logic [6:0] RST_COLS   = 7'd64;
	localparam logic [3:0] RST_SIGMA  = 4'd1;
	localparam logic [1:0] RST_RADIUS = 2'd1;

	// columns: d2 = 0,1,2,4,5,8,9,10,13,18
	localparam logic [WGT_W-1:0] WROM [8][10] = '{
		'{16'd32768, 16'd19875, 16'd12055, 16'd4435,  16'd2690,
		  16'd600,   16'd364,   16'd221,   16'd49,    16'd4},
		'{16'd32768, 16'd28918, 16'd25520, 16'd19875, 16'd17539,
		  16'd12055, 16'd10638, 16'd9388,  16'd6452,  16'd3454},
		'{16'd32768, 16'd30997, 16'd29322, 16'd26239, 16'd24821,
		  16'd21010, 16'd19875, 16'd18801, 16'd15914, 16'd12055},
		'{16'd32768, 16'd31760, 16'd30783, 16'd28918, 16'd28028,
		  16'd25520, 16'd24735, 16'd23974, 16'd21828, 16'd18671},
		'{16'd32768, 16'd32119, 16'd31483, 16'd30249, 16'd29650,
		  16'd27923, 16'd27370, 16'd26828, 16'd25266, 16'd22861},
		'{16'd32768, 16'd32316, 16'd31870, 16'd30997, 16'd30570,
		  16'd29322, 16'd28918, 16'd28519, 16'd27355, 16'd25520},
		'{16'd32768, 16'd32435, 16'd32106, 16'd31457, 16'd31138,
		  16'd30199, 16'd29893, 16'd29589, 16'd28697, 16'd27270},
		'{16'd32768, 16'd32513, 16'd32260, 16'd31760, 16'd31513,
		  16'd30783, 16'd30543, 16'd30305, 16'd29603, 16'd28469}
	};

	localparam logic [3:0] DCOL [4][4] = '{
		'{4'd0, 4'd1, 4'd3, 4'd6},
		'{4'd1, 4'd2, 4'd4, 4'd7},
		'{4'd3, 4'd4, 4'd5, 4'd8},
		'{4'd6, 4'd7, 4'd8, 4'd9}
	};

	function automatic logic [WGT_W-1:0] weight(logic [2:0] sidx, logic [1:0] ay,
			logic [1:0] ax);
		return WROM[sidx][DCOL[ay][ax]];
	endfunction

endpackage

`default_nettype wire

// ===== sv/gbr_if.sv =====
// ----------------------------------------------------------------------------
// Gaussian blur channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbr_req_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [gbr_pkg::COORD_W-1:0]  row;
	logic [gbr_pkg::COORD_W-1:0]  col;
	logic [gbr_pkg::CH_W-1:0]     in_red;
	logic [gbr_pkg::CH_W-1:0]     in_green;
	logic [gbr_pkg::CH_W-1:0]     in_blue;
	logic [gbr_pkg::CH_W-1:0]     in_alpha;

	modport source(output valid, opcode, row, col, in_red, in_green, in_blue, in_alpha,
		input ready);
	modport sink(input valid, opcode, row, col, in_red, in_green, in_blue, in_alpha,
		output ready);
endinterface

interface gbr_res_if;
	logic                      valid;
	logic                      ready;
	logic                      is_blur;
	logic [gbr_pkg::CH_W-1:0]  out_red;
	logic [gbr_pkg::CH_W-1:0]  out_green;
	logic [gbr_pkg::CH_W-1:0]  out_blue;
	logic [gbr_pkg::CH_W-1:0]  out_alpha;

	modport source(output valid, is_blur, out_red, out_green, out_blue, out_alpha,
		input ready);
	modport sink(input valid, is_blur, out_red, out_green, out_blue, out_alpha,
		output ready);
endinterface

`default_nettype wire

// ===== sv/gbr_ram.sv =====
// ----------------------------------------------------------------------------
// Gaussian blur generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire logic [WIDTH-1:0]      wdata,
	input  wire logic [AW-1:0]         raddr,
	output      logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

// ===== sv/gaussian_blur_rgba_clamped.sv =====
// Store request: result register loaded when the request is accepted.
// Blur request: (2r+1)^2 window reads, one per cycle from the single RAM read port,
// then the drain and load states, a shared restoring division over the four channels
// (8 quotient bits each) and the result register, loaded once that register is free.
// One request in flight at a time; ready again once the result register is free.
// Async reset clears control and configuration; the image RAM is not cleared.
// ----------------------------------------------------------------------------
// Gaussian blur RGBA, clamped edges
// Stores pixels and returns Gaussian-weighted window averages per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_rgba_clamped #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int MAX_RADIUS = 3
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gbr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gbr_pkg::CFG_W-1:0]     cfg_wdata,
	gbr_req_if.sink                            req,
	gbr_res_if.source                          res
);
	`include "gaussian_blur_rgba_clamped_assert.svh"

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ACC_W  = gbr_pkg::ACC_W;
	localparam int WSUM_W = gbr_pkg::WSUM_W;
	localparam int PROD_W = gbr_pkg::PROD_W;
	localparam int CH_W   = gbr_pkg::CH_W;
	localparam logic [1:0] RAD_LIM = 2'((MAX_RADIUS > 3) ? 3 : MAX_RADIUS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]                 state_q;
	logic [6:0]                 rows_q, cols_q;
	logic [3:0]                 sigma_q;
	logic [1:0]                 radius_q;
	logic [6:0]                 rows_eff, cols_eff;
	logic [2:0]                 sidx;
	logic [1:0]                 r_eff;
	logic signed [2:0]          r_s;

	logic [gbr_pkg::COORD_W-1:0] row_q, col_q;
	logic signed [2:0]          dy_q, dx_q;
	logic signed [8:0]          y_raw, x_raw;
	logic [6:0]                 y_cl, x_cl;
	logic [1:0]                 ay_w, ax_w;
	logic [gbr_pkg::WGT_W-1:0]  wgt;

	logic                       v_s1;
	logic [gbr_pkg::WGT_W-1:0]  w_s1;
	logic [gbr_pkg::PIX_W-1:0]  rdata;
	logic [PROD_W-1:0]          prod [4];
	logic [ACC_W-1:0]           acc_q [4];
	logic [WSUM_W-1:0]          wsum_q;

	logic [ACC_W-1:0]           rem_q, dsh;
	logic                       ge;
	logic [2:0]                 bit_q;
	logic [1:0]                 ch_q;
	logic [CH_W-1:0]            qacc_q, qnext;
	logic [CH_W-1:0]            blur_q [4];

	logic                       ov_q, ob_q;
	logic [CH_W-1:0]            oc_q [4];
	logic                       out_free, req_acc, ld_store, ld_blur, wr_en;
	logic [AW-1:0]              waddr, raddr;

	function automatic logic [6:0] clamp(logic signed [8:0] v, logic [6:0] lim);
		logic [6:0] r;
		if (v < 0) begin
			r = 7'd0;
		end else if (v >= $signed({2'b00, lim})) begin
			r = lim - 7'd1;
		end else begin
			r = v[6:0];
		end
		return r;
	endfunction

	// effective configuration
	always_comb begin
		rows_eff = (rows_q == 7'd0) ? 7'd1 : ((int'(rows_q) > MAX_ROWS) ? 7'(MAX_ROWS) : rows_q);
		cols_eff = (cols_q == 7'd0) ? 7'd1 : ((int'(cols_q) > MAX_COLS) ? 7'(MAX_COLS) : cols_q);
		if (sigma_q == 4'd0) begin
			sidx = 3'd0;
		end else if (sigma_q > 4'd8) begin
			sidx = 3'd7;
		end else begin
			sidx = 3'(sigma_q - 4'd1);
		end
		r_eff = (radius_q > RAD_LIM) ? RAD_LIM : radius_q;
	end
	assign r_s = signed'({1'b0, r_eff});

	// window address and weight
	assign y_raw = $signed({3'b000, row_q}) + 9'(dy_q);
	assign x_raw = $signed({3'b000, col_q}) + 9'(dx_q);
	assign y_cl  = clamp(y_raw, rows_eff);
	assign x_cl  = clamp(x_raw, cols_eff);
	assign raddr = AW'(int'(y_cl) * MAX_COLS + int'(x_cl));
	assign ay_w  = dy_q[2] ? 2'(-dy_q) : 2'(dy_q);
	assign ax_w  = dx_q[2] ? 2'(-dx_q) : 2'(dx_q);
	assign wgt   = gbr_pkg::weight(sidx, ay_w, ax_w);

	// handshake
	assign out_free = !ov_q || res.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign req_acc  = req.valid && req.ready;
	assign ld_store = req_acc && (req.opcode == gbr_pkg::OP_STORE);
	assign ld_blur  = (state_q == ST_FIN) && out_free;

	assign wr_en = ld_store && (int'(req.row) < MAX_ROWS) && (int'(req.col) < MAX_COLS);
	assign waddr = AW'(int'(req.row) * MAX_COLS + int'(req.col));

	gbr_ram #(
		.WIDTH(gbr_pkg::PIX_W),
		.DEPTH(DEPTH)
	) u_img (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata({req.in_alpha, req.in_blue, req.in_green, req.in_red}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// shared divider step
	assign dsh   = ACC_W'(wsum_q) << bit_q;
	assign ge    = rem_q >= dsh;
	assign qnext = {qacc_q[CH_W-2:0], ge};

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			prod[c] = w_s1 * rdata[8*c +: 8];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= gbr_pkg::RST_ROWS;
			cols_q   <= gbr_pkg::RST_COLS;
			sigma_q  <= gbr_pkg::RST_SIGMA;
			radius_q <= gbr_pkg::RST_RADIUS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gbr_pkg::CFG_ROWS:   rows_q   <= cfg_wdata;
				gbr_pkg::CFG_COLS:   cols_q   <= cfg_wdata;
				gbr_pkg::CFG_SIGMA:  sigma_q  <= cfg_wdata[3:0];
				gbr_pkg::CFG_RADIUS: radius_q <= cfg_wdata[1:0];
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
			dy_q    <= 3'sd0;
			dx_q    <= 3'sd0;
			bit_q   <= 3'd0;
			ch_q    <= 2'd0;
			ov_q    <= 1'b0;
		end else begin
			v_s1 <= 1'b0;
			if (ld_store || ld_blur) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && (req.opcode == gbr_pkg::OP_BLUR)) begin
						dy_q    <= -r_s;
						dx_q    <= -r_s;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					v_s1 <= 1'b1;
					if (dx_q == r_s) begin
						dx_q <= -r_s;
						if (dy_q == r_s) begin
							state_q <= ST_DRAIN;
						end else begin
							dy_q <= dy_q + 3'sd1;
						end
					end else begin
						dx_q <= dx_q + 3'sd1;
					end
				end
				ST_DRAIN: state_q <= ST_LOAD;
				ST_LOAD: begin
					ch_q    <= 2'd0;
					bit_q   <= 3'd7;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (bit_q == 3'd0) begin
						bit_q <= 3'd7;
						if (ch_q == 2'd3) begin
							state_q <= ST_FIN;
						end else begin
							ch_q <= ch_q + 2'd1;
						end
					end else begin
						bit_q <= bit_q - 3'd1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_acc) begin
			row_q <= req.row;
			col_q <= req.col;
		end
		w_s1 <= wgt;
		if (req_acc) begin
			for (int c = 0; c < 4; c++) begin
				acc_q[c] <= '0;
			end
			wsum_q <= '0;
		end else if (v_s1) begin
			for (int c = 0; c < 4; c++) begin
				acc_q[c] <= acc_q[c] + ACC_W'(prod[c]);
			end
			wsum_q <= wsum_q + WSUM_W'(w_s1);
		end
		if (state_q == ST_LOAD) begin
			rem_q  <= acc_q[0];
			qacc_q <= '0;
		end else if (state_q == ST_DIV) begin
			if (bit_q == 3'd0) begin
				blur_q[ch_q] <= qnext;
				rem_q        <= acc_q[2'(ch_q + 2'd1)];
				qacc_q       <= '0;
			end else begin
				rem_q  <= ge ? (rem_q - dsh) : rem_q;
				qacc_q <= qnext;
			end
		end
		if (ld_store) begin
			ob_q <= 1'b0;
			for (int c = 0; c < 4; c++) begin
				oc_q[c] <= '0;
			end
		end else if (ld_blur) begin
			ob_q <= 1'b1;
			for (int c = 0; c < 4; c++) begin
				oc_q[c] <= blur_q[c];
			end
		end
	end

	assign res.valid     = ov_q;
	assign res.is_blur   = ob_q;
	assign res.out_red   = oc_q[0];
	assign res.out_green = oc_q[1];
	assign res.out_blue  = oc_q[2];
	assign res.out_alpha = oc_q[3];

	`GBR_ASSERT_NXT(a_blur_walk, req_acc && (req.opcode == gbr_pkg::OP_BLUR), state_q == ST_WALK, "blur request did not start the window walk")
	`GBR_ASSERT_IMP(a_drain_read, state_q == ST_DRAIN, v_s1, "last window read not in flight at drain")
	`GBR_ASSERT_IMP(a_wsum_centre, state_q == ST_DIV, wsum_q >= WSUM_W'(32768), "weight sum lacks centre weight")
	`GBR_ASSERT_IMP(a_rem_bound, state_q == ST_DIV, (rem_q >> bit_q) < (wsum_q + wsum_q), "division remainder out of range")
endmodule

`default_nettype wire
